[sv/segment_box_slab_test_assert.svh]
// Assertion macros for the segment/box slab test block.
// Uses the clock i_clk and the synchronous active-low reset i_rst_n of the
// module that includes it.
`ifndef SEGMENT_BOX_SLAB_TEST_ASSERT_SVH
`define SEGMENT_BOX_SLAB_TEST_ASSERT_SVH

// cons must hold in the same cycle as ante
`define SBST_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sbst: same-cycle check failed");

// cons must hold in the cycle after ante
`define SBST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sbst: next-cycle check failed");

`endif

[sv/sbst_pkg.sv]
// Package for the segment/box slab test: widths, beat structs, fraction type.
// No dependencies.
`default_nettype none

package sbst_pkg;

    localparam int COORD_BITS = 16;
    // box bounds need one more bit than a coordinate
    localparam int BND_BITS   = COORD_BITS + 1;
    // slab numerators (bound minus start)
    localparam int NUM_BITS   = COORD_BITS + 2;
    // direction magnitude, kept signed and never negative
    localparam int DEN_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS  = NUM_BITS + DEN_BITS;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic signed [COORD_BITS-1:0] box_origin_x;
        logic signed [COORD_BITS-1:0] box_origin_y;
        logic signed [COORD_BITS-1:0] box_size_x;
        logic signed [COORD_BITS-1:0] box_size_y;
    } t_seg_in;

    typedef struct packed {
        logic hit;
        logic endpoint_inside;
    } t_seg_out;

    typedef struct packed {
        logic signed [NUM_BITS-1:0] num;
        logic signed [DEN_BITS-1:0] den;
    } t_frac;

    // decoded item: endpoint test done, per-axis slab fractions ready
    typedef struct packed {
        logic  ep_in;
        logic  fail;
        logic  bnd_x;
        logic  bnd_y;
        t_frac en_x;
        t_frac ex_x;
        t_frac en_y;
        t_frac ex_y;
    } t_dec;

endpackage

`default_nettype wire

[sv/sbst_decode.sv]
// Front-end decode: box bounds, endpoint-in-box test, per-axis slab fractions.
// Depends on sbst_pkg.
`default_nettype none

module sbst_decode (
    input  sbst_pkg::t_seg_in i_item,
    output sbst_pkg::t_dec    o_dec
);

    typedef struct packed {
        logic             bnd;
        logic             miss;
        logic             in_s;
        logic             in_e;
        sbst_pkg::t_frac  en;
        sbst_pkg::t_frac  ex;
    } t_axis;

    function automatic t_axis axis_dec(
        input logic signed [sbst_pkg::COORD_BITS-1:0] s,
        input logic signed [sbst_pkg::COORD_BITS-1:0] e,
        input logic signed [sbst_pkg::COORD_BITS-1:0] o,
        input logic signed [sbst_pkg::COORD_BITS-1:0] z
    );
        logic signed [sbst_pkg::NUM_BITS-1:0] sw, ew, ow, zw, zn, zp, lo, hi, d, dn;
        t_axis r;
        sw = sbst_pkg::NUM_BITS'(s);
        ew = sbst_pkg::NUM_BITS'(e);
        ow = sbst_pkg::NUM_BITS'(o);
        zw = sbst_pkg::NUM_BITS'(z);
        zn = (zw < 0) ? zw : sbst_pkg::NUM_BITS'(0);
        zp = (zw > 0) ? zw : sbst_pkg::NUM_BITS'(0);
        lo = ow + zn;
        hi = ow + zp;
        d  = ew - sw;
        dn = -d;
        r.in_s = (sw >= lo) && (sw <= hi);
        r.in_e = (ew >= lo) && (ew <= hi);
        r.bnd  = (d != 0);
        // flat direction: start outside the slab rules the segment out
        r.miss = (d == 0) && !r.in_s;
        if (d > 0) begin
            r.en.num = lo - sw;
            r.ex.num = hi - sw;
            r.en.den = d[sbst_pkg::DEN_BITS-1:0];
        end else begin
            r.en.num = sw - hi;
            r.ex.num = sw - lo;
            r.en.den = dn[sbst_pkg::DEN_BITS-1:0];
        end
        r.ex.den = r.en.den;
        return r;
    endfunction

    t_axis w_ax_x;
    t_axis w_ax_y;

    always_comb begin
        w_ax_x = axis_dec(i_item.start_x, i_item.end_x, i_item.box_origin_x,
                          i_item.box_size_x);
        w_ax_y = axis_dec(i_item.start_y, i_item.end_y, i_item.box_origin_y,
                          i_item.box_size_y);
        o_dec.ep_in  = (w_ax_x.in_s && w_ax_y.in_s) || (w_ax_x.in_e && w_ax_y.in_e);
        o_dec.fail   = w_ax_x.miss || w_ax_y.miss || (!w_ax_x.bnd && !w_ax_y.bnd);
        o_dec.bnd_x  = w_ax_x.bnd;
        o_dec.bnd_y  = w_ax_y.bnd;
        o_dec.en_x   = w_ax_x.en;
        o_dec.ex_x   = w_ax_x.ex;
        o_dec.en_y   = w_ax_y.en;
        o_dec.ex_y   = w_ax_y.ex;
    end

endmodule

`default_nettype wire

[sv/segment_box_slab_test.sv]
// Top level of the segment versus axis-aligned box slab test pipeline.
// Depends on sbst_pkg, sbst_decode and segment_box_slab_test_assert.svh.
// ----------------------------------------------------------------------------
//  channel | valid        | ready        | payload                 | beat
//  input   | i_in_valid   | o_in_ready   | i_in_item  (t_seg_in)   | one segment+box
//  output  | o_out_valid  | i_out_ready  | o_out_item (t_seg_out)  | one hit verdict
// ----------------------------------------------------------------------------
// One beat per cycle sustained while i_out_ready is high. Depth is set by the
// two 18x17 cross-multiply stages (axis ordering, then entry versus exit),
// each followed by a register before the compare.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage loads when its successor has room, so bubbles are squeezed out
// and input beats keep flowing while a result waits, until all six stages fill.
`default_nettype none

module segment_box_slab_test (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  sbst_pkg::t_seg_in  i_in_item,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output sbst_pkg::t_seg_out o_out_item
);

`include "segment_box_slab_test_assert.svh"

    // stage 2: axis-ordering products
    typedef struct packed {
        logic                                 ep_in;
        logic                                 fail;
        logic                                 bnd_x;
        logic                                 bnd_y;
        sbst_pkg::t_frac                      en_x;
        sbst_pkg::t_frac                      ex_x;
        sbst_pkg::t_frac                      en_y;
        sbst_pkg::t_frac                      ex_y;
        logic signed [sbst_pkg::PROD_BITS-1:0] pe_yx;
        logic signed [sbst_pkg::PROD_BITS-1:0] pe_xy;
        logic signed [sbst_pkg::PROD_BITS-1:0] px_yx;
        logic signed [sbst_pkg::PROD_BITS-1:0] px_xy;
    } t_s2;

    // stage 3: chosen entry and exit
    typedef struct packed {
        logic            ep_in;
        logic            fail;
        sbst_pkg::t_frac entry;
        sbst_pkg::t_frac exitv;
    } t_s3;

    // stage 4: entry/exit cross products and the t window check
    typedef struct packed {
        logic                                 ep_in;
        logic                                 fail;
        logic                                 exit_neg;
        logic                                 t_ok;
        logic signed [sbst_pkg::PROD_BITS-1:0] p_a;
        logic signed [sbst_pkg::PROD_BITS-1:0] p_b;
    } t_s4;

    function automatic logic signed [sbst_pkg::PROD_BITS-1:0] mul_nd(
        input logic signed [sbst_pkg::NUM_BITS-1:0] num,
        input logic signed [sbst_pkg::DEN_BITS-1:0] den
    );
        logic signed [sbst_pkg::PROD_BITS-1:0] a, b;
        a = sbst_pkg::PROD_BITS'(num);
        b = sbst_pkg::PROD_BITS'(den);
        return a * b;
    endfunction

    // stage valids: 0 input reg, 1 decode, 2 products, 3 select, 4 products, 5 result
    logic [5:0]         r_v;
    logic [5:0]         w_take;

    sbst_pkg::t_seg_in  r_s0;
    sbst_pkg::t_dec     r_s1;
    t_s2                r_s2;
    t_s3                r_s3;
    t_s4                r_s4;
    sbst_pkg::t_seg_out r_out;

    sbst_pkg::t_dec     n_s1;
    t_s2                n_s2;
    t_s3                n_s3;
    t_s4                n_s4;
    sbst_pkg::t_seg_out n_out;
    sbst_pkg::t_frac    w_t;

    // a stage takes a beat when it is empty or its own beat moves on
    always_comb begin
        w_take[5] = !r_v[5] || i_out_ready;
        w_take[4] = !r_v[4] || w_take[5];
        w_take[3] = !r_v[3] || w_take[4];
        w_take[2] = !r_v[2] || w_take[3];
        w_take[1] = !r_v[1] || w_take[2];
        w_take[0] = !r_v[0] || w_take[1];
    end

    assign o_in_ready  = w_take[0];
    assign o_out_valid = r_v[5];
    assign o_out_item  = r_out;

    sbst_decode u_decode (
        .i_item (r_s0),
        .o_dec  (n_s1)
    );

    always_comb begin
        n_s2.ep_in  = r_s1.ep_in;
        n_s2.fail   = r_s1.fail;
        n_s2.bnd_x  = r_s1.bnd_x;
        n_s2.bnd_y  = r_s1.bnd_y;
        n_s2.en_x   = r_s1.en_x;
        n_s2.ex_x   = r_s1.ex_x;
        n_s2.en_y   = r_s1.en_y;
        n_s2.ex_y   = r_s1.ex_y;
        n_s2.pe_yx  = mul_nd(r_s1.en_y.num, r_s1.en_x.den);
        n_s2.pe_xy  = mul_nd(r_s1.en_x.num, r_s1.en_y.den);
        n_s2.px_yx  = mul_nd(r_s1.ex_y.num, r_s1.ex_x.den);
        n_s2.px_xy  = mul_nd(r_s1.ex_x.num, r_s1.ex_y.den);
    end

    // with both axes bounded, entry is the later of the axis entries, exit the
    // earlier of the exits, and a tie keeps x; else the bounded axis gives both
    always_comb begin
        n_s3.ep_in  = r_s2.ep_in;
        n_s3.fail   = r_s2.fail;
        if (r_s2.bnd_x && r_s2.bnd_y) begin
            n_s3.entry = (r_s2.pe_yx > r_s2.pe_xy) ? r_s2.en_y : r_s2.en_x;
            n_s3.exitv = (r_s2.px_yx < r_s2.px_xy) ? r_s2.ex_y : r_s2.ex_x;
        end else if (r_s2.bnd_x) begin
            n_s3.entry = r_s2.en_x;
            n_s3.exitv = r_s2.ex_x;
        end else begin
            n_s3.entry = r_s2.en_y;
            n_s3.exitv = r_s2.ex_y;
        end
    end

    always_comb begin
        w_t           = (r_s3.entry.num < 0) ? r_s3.exitv : r_s3.entry;
        n_s4.ep_in    = r_s3.ep_in;
        n_s4.fail     = r_s3.fail;
        n_s4.exit_neg = (r_s3.exitv.num < 0);
        n_s4.t_ok     = (w_t.num > 0) && (w_t.num < sbst_pkg::NUM_BITS'(w_t.den));
        n_s4.p_a      = mul_nd(r_s3.entry.num, r_s3.exitv.den);
        n_s4.p_b      = mul_nd(r_s3.exitv.num, r_s3.entry.den);
    end

    // an endpoint in the box wins outright; else the slab verdict
    always_comb begin
        n_out.endpoint_inside = r_s4.ep_in;
        n_out.hit = r_s4.ep_in ||
                    (!r_s4.fail && !r_s4.exit_neg && !(r_s4.p_a > r_s4.p_b) && r_s4.t_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_take[0]) r_v[0] <= i_in_valid;
            if (w_take[1]) r_v[1] <= r_v[0];
            if (w_take[2]) r_v[2] <= r_v[1];
            if (w_take[3]) r_v[3] <= r_v[2];
            if (w_take[4]) r_v[4] <= r_v[3];
            if (w_take[5]) r_v[5] <= r_v[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take[0]) r_s0  <= i_in_item;
        if (w_take[1]) r_s1  <= n_s1;
        if (w_take[2]) r_s2  <= n_s2;
        if (w_take[3]) r_s3  <= n_s3;
        if (w_take[4]) r_s4  <= n_s4;
        if (w_take[5]) r_out <= n_out;
    end

    // input back-pressure only when every stage holds a beat
    `SBST_ASSERT_SAME(a_ready_full, !o_in_ready, &r_v)
    // a held beat in the last product stage keeps its payload
    `SBST_ASSERT_NEXT(a_s4_hold, r_v[4] && !w_take[5], r_v[4] && $stable(r_s4))
    // an endpoint verdict is always a hit
    `SBST_ASSERT_SAME(a_ep_hit, o_out_valid && o_out_item.endpoint_inside, o_out_item.hit)
    // a new result only appears from a filled stage 4
    `SBST_ASSERT_SAME(a_out_src, $rose(o_out_valid), $past(r_v[4]))

endmodule

`default_nettype wire
